// ===== src/lcd_decimal_field_writer_defines.svh =====
// Assertion macros used by the LCD decimal field writer.
`ifndef LCD_DECIMAL_FIELD_WRITER_DEFINES_SVH
`define LCD_DECIMAL_FIELD_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LCD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcd decimal field writer: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LCD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcd decimal field writer: assertion failed");
`else
`define LCD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LCD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/lcd_dfw_pkg.sv =====
`timescale 1ns / 1ps
package lcd_dfw_pkg;

  // Fixed byte codes of the character display.
  localparam logic [7:0] HOME_CMD   = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ERR_CHAR   = 8'h45;

  // Five decimal digits at most, plus one cursor command.
  localparam int MAX_DIGITS = 5;
  localparam int NUM_SLOTS  = 6;

  // Reciprocal of 100 for values below 10000.
  localparam logic [13:0] REC100       = 14'd5243;
  localparam int          REC100_SHIFT = 19;

  typedef logic [3:0] digit_t;

  // One byte on the display bus with its register select.
  typedef struct packed {
    logic       is_data;
    logic [7:0] data;
  } lcd_sym_t;

  // Cursor command and digit request of one item.
  typedef struct packed {
    logic       cmd_en;
    logic [7:0] cmd_byte;
    logic [3:0] count;
  } head_t;

  // Item with its value already split into decimal digits.
  typedef struct packed {
    head_t                        head;
    digit_t [MAX_DIGITS-1:0]      digits;
  } digit_item_t;

  // DDRAM base address command of rows one to four.
  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] base;
    case (idx)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      2'd3:    base = 8'hD4;
      default: base = 8'h80;
    endcase
    return base;
  endfunction

  // Splits a value below 100 into tens and ones with a compare ladder.
  function automatic logic [7:0] split_tens(input logic [6:0] x);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    ones = x - 7'(int'(tens) * 10);
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== src/lcd_dfw_pipe.sv =====
`timescale 1ns / 1ps
module lcd_dfw_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_row,
  input  logic [5:0]               in_column,
  input  logic [15:0]              in_value,
  input  logic [3:0]               in_digit_count,
  output logic                     item_valid,
  input  logic                     item_ready,
  output lcd_dfw_pkg::digit_item_t item
);

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // Stage one: captured input fields.
  logic [2:0]  row_r;
  logic [5:0]  column_r;
  logic [15:0] value_r;
  logic [3:0]  count_r;

  // Stage two: ten-thousands digit and remainder.
  lcd_dfw_pkg::head_t head2_r;
  logic [2:0]         q4_2_r;
  logic [13:0]        rem2_r;

  // Stage three: hundreds part found.
  lcd_dfw_pkg::head_t head3_r;
  logic [2:0]         q4_3_r;
  logic [13:0]        rem3_r;
  logic [6:0]         hi3_r;

  // Stage four: two pairs of digits below 100.
  lcd_dfw_pkg::head_t head4_r;
  logic [2:0]         q4_4_r;
  logic [6:0]         hi4_r;
  logic [6:0]         lo4_r;

  lcd_dfw_pkg::head_t head_nxt;
  logic [2:0]         q4_nxt;
  logic [15:0]        rem_full;
  logic [26:0]        prod;
  logic [6:0]         hi_nxt;
  logic [13:0]        lo_full;
  logic [7:0]         hi_pair;
  logic [7:0]         lo_pair;

  // A stage takes new data when it is empty or its contents move on.
  assign en4      = !v4_r || item_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Cursor command and ten-thousands digit from the raw fields.
  always_comb begin
    head_nxt.count = count_r;
    if ((row_r == 3'd0) || (column_r == 6'd0)) begin
      head_nxt.cmd_en   = 1'b1;
      head_nxt.cmd_byte = lcd_dfw_pkg::HOME_CMD;
    end else if (row_r <= 3'd4) begin
      head_nxt.cmd_en   = 1'b1;
      head_nxt.cmd_byte = lcd_dfw_pkg::row_base(2'(row_r - 3'd1)) + {2'b00, column_r} - 8'd1;
    end else begin
      head_nxt.cmd_en   = 1'b0;
      head_nxt.cmd_byte = lcd_dfw_pkg::HOME_CMD;
    end
    q4_nxt = '0;
    for (int k = 1; k < 7; k++) begin
      if (value_r >= 16'(k * 10000)) begin
        q4_nxt = 3'(k);
      end
    end
    rem_full = value_r - 16'(int'(q4_nxt) * 10000);
  end

  // Hundreds by reciprocal multiplication, exact below 10000.
  assign prod   = 27'(rem2_r) * 27'(lcd_dfw_pkg::REC100);
  assign hi_nxt = 7'(prod >> lcd_dfw_pkg::REC100_SHIFT);

  // Remainder below 100.
  assign lo_full = rem3_r - 14'(hi3_r) * 14'd100;

  always_ff @(posedge clk) begin
    if (en1) begin
      row_r    <= in_row;
      column_r <= in_column;
      value_r  <= in_value;
      count_r  <= in_digit_count;
    end
    if (en2) begin
      head2_r <= head_nxt;
      q4_2_r  <= q4_nxt;
      rem2_r  <= rem_full[13:0];
    end
    if (en3) begin
      head3_r <= head2_r;
      q4_3_r  <= q4_2_r;
      rem3_r  <= rem2_r;
      hi3_r   <= hi_nxt;
    end
    if (en4) begin
      head4_r <= head3_r;
      q4_4_r  <= q4_3_r;
      hi4_r   <= hi3_r;
      lo4_r   <= lo_full[6:0];
    end
  end

  // Final split of both pairs into single digits.
  assign hi_pair    = lcd_dfw_pkg::split_tens(hi4_r);
  assign lo_pair    = lcd_dfw_pkg::split_tens(lo4_r);
  assign item_valid = v4_r;

  always_comb begin
    item.head      = head4_r;
    item.digits[4] = {1'b0, q4_4_r};
    item.digits[3] = hi_pair[7:4];
    item.digits[2] = hi_pair[3:0];
    item.digits[1] = lo_pair[7:4];
    item.digits[0] = lo_pair[3:0];
  end

endmodule

// ===== src/lcd_dfw_ser.sv =====
`timescale 1ns / 1ps
`include "lcd_decimal_field_writer_defines.svh"
module lcd_dfw_ser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  lcd_dfw_pkg::digit_item_t item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_data,
  output logic [7:0]               out_lcd_byte,
  output logic                     out_last
);

  lcd_dfw_pkg::lcd_sym_t slot_r   [lcd_dfw_pkg::NUM_SLOTS];
  lcd_dfw_pkg::lcd_sym_t slot_nxt [lcd_dfw_pkg::NUM_SLOTS];
  lcd_dfw_pkg::lcd_sym_t dsym     [lcd_dfw_pkg::NUM_SLOTS];
  logic [2:0]            left_r;
  logic [2:0]            n_new;
  logic [2:0]            nd;
  logic [3:0]            di;
  logic                  load;
  logic                  take;

  // The byte list of an item, with an unused tail of zeros.
  always_comb begin
    for (int j = 0; j < lcd_dfw_pkg::NUM_SLOTS; j++) begin
      dsym[j] = '0;
    end
    di = '0;
    if (item.head.count > 4'd5) begin
      nd      = 3'd1;
      dsym[0] = '{is_data: 1'b1, data: lcd_dfw_pkg::ERR_CHAR};
    end else begin
      nd = item.head.count[2:0];
      for (int j = 0; j < lcd_dfw_pkg::MAX_DIGITS; j++) begin
        di = item.head.count - 4'(j) - 4'd1;
        if ((4'(j) < item.head.count) && (di < 4'd5)) begin
          dsym[j] = '{is_data: 1'b1,
                      data: lcd_dfw_pkg::ASCII_ZERO + {4'b0000, item.digits[di[2:0]]}};
        end
      end
    end
    // The cursor command, when present, goes first.
    for (int i = 0; i < lcd_dfw_pkg::NUM_SLOTS; i++) begin
      if (item.head.cmd_en) begin
        if (i == 0) begin
          slot_nxt[i] = '{is_data: 1'b0, data: item.head.cmd_byte};
        end else begin
          slot_nxt[i] = dsym[i-1];
        end
      end else begin
        slot_nxt[i] = dsym[i];
      end
    end
    n_new = nd + {2'b00, item.head.cmd_en};
  end

  // A new item loads once the last byte of the previous one is transferred.
  assign out_valid  = (left_r != 3'd0);
  assign take       = out_valid && out_ready;
  assign item_ready = (left_r == 3'd0) || ((left_r == 3'd1) && out_ready);
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= n_new;
    end else if (take) begin
      left_r <= left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= slot_nxt;
    end else if (take) begin
      for (int i = 0; i < lcd_dfw_pkg::NUM_SLOTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
      slot_r[lcd_dfw_pkg::NUM_SLOTS-1] <= '0;
    end
  end

  assign out_is_data  = slot_r[0].is_data;
  assign out_lcd_byte = slot_r[0].data;
  assign out_last     = (left_r == 3'd1);

  // An item with bytes to send is shown in the next cycle.
  `LCD_ASSERT_NXT(a_load_shows, clk, rst_n, load && (n_new != 3'd0), out_valid)
  // A transfer that is not the last one leaves more bytes waiting.
  `LCD_ASSERT_NXT(a_more_follow, clk, rst_n, take && !out_last, out_valid)
  // Only the first byte of an item can be a command.
  `LCD_ASSERT_NXT(a_cmd_first, clk, rst_n, take && !out_last, out_is_data)

endmodule

// ===== src/lcd_decimal_field_writer.sv =====
`timescale 1ns / 1ps
// Path: an item passes the four-stage digit pipeline and is then loaded into the
// output register, which shows its first byte. Throughput: one input transfer per
// cycle while in_ready is high; one output byte per cycle while out_ready is high,
// up to six bytes per item (cursor command plus digits); an empty item sends none.
// Reset: synchronous, active low; it empties the pipeline and the output register.
module lcd_decimal_field_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_row,
  input  logic [5:0]  in_column,
  input  logic [15:0] in_value,
  input  logic [3:0]  in_digit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_data,
  output logic [7:0]  out_lcd_byte,
  output logic        out_last
);

  logic                     item_valid;
  logic                     item_ready;
  lcd_dfw_pkg::digit_item_t item;

  // Cursor command and decimal digits of each item.
  lcd_dfw_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item)
  );

  // Byte stream towards the display bus.
  lcd_dfw_ser u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_data  (out_is_data),
    .out_lcd_byte (out_lcd_byte),
    .out_last     (out_last)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  // Register select values of a byte on the display bus.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic DATA_BYTE = 1'b1;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // One byte transfer as it should leave the block.
  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_xfer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_row = '0;
  logic [5:0]  in_column = '0;
  logic [15:0] in_value = '0;
  logic [3:0]  in_digit_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_data;
  logic [7:0]  out_lcd_byte;
  logic        out_last;

  lcd_xfer_t expected_bytes[$];
  lcd_xfer_t next_expected;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;

  lcd_decimal_field_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_data    (out_is_data),
    .out_lcd_byte   (out_lcd_byte),
    .out_last       (out_last)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the byte stream that one request should give and queues it.
  task automatic predict_lcd_bytes(input logic [2:0] row, input logic [5:0] column,
                                   input logic [15:0] value, input logic [3:0] count);
    int        queued_before;
    int        divisor;
    int        digit;
    logic [7:0] base;
    queued_before = expected_bytes.size();
    // Cursor command: home, a row address, or nothing for rows beyond four.
    if (row == 3'd0 || column == 6'd0) begin
      expected_bytes.push_back('{CMD_BYTE, lcd_dfw_pkg::HOME_CMD, 1'b0});
    end else if (row <= 3'd4) begin
      case (row)
        3'd1:    base = 8'h80;
        3'd2:    base = 8'hC0;
        3'd3:    base = 8'h94;
        default: base = 8'hD4;
      endcase
      expected_bytes.push_back('{CMD_BYTE, 8'(base + {2'b00, column} - 8'd1), 1'b0});
    end
    // Digits, most significant first; a fifth digit is not reduced modulo ten.
    if (count > 4'd5) begin
      expected_bytes.push_back('{DATA_BYTE, lcd_dfw_pkg::ERR_CHAR, 1'b0});
    end else begin
      for (int d = count; d > 0; d--) begin
        divisor = 1;
        repeat (d - 1) divisor = divisor * 10;
        digit = int'(value) / divisor;
        if (d != lcd_dfw_pkg::MAX_DIGITS) digit = digit % 10;
        expected_bytes.push_back('{DATA_BYTE, 8'(lcd_dfw_pkg::ASCII_ZERO + digit), 1'b0});
      end
    end
    if (expected_bytes.size() > queued_before) expected_bytes[$].last = 1'b1;
  endtask

  // Offers one request, at times with a random gap first, and holds it until the transfer.
  task automatic send_request(input logic [2:0] row, input logic [5:0] column,
                              input logic [15:0] value, input logic [3:0] count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_row         <= row;
    in_column      <= column;
    in_value       <= value;
    in_digit_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_lcd_bytes(row, column, value, count);
  endtask

  // Result side back-pressure in random bursts while idling is switched on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares every result transfer with the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("ERROR: unexpected byte is_data=%0b byte=%02h last=%0b",
                   out_is_data, out_lcd_byte, out_last);
      end else begin
        next_expected = expected_bytes.pop_front();
        if (out_is_data !== next_expected.is_data || out_lcd_byte !== next_expected.lcd_byte ||
            out_last !== next_expected.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("ERROR: expected is_data=%0b byte=%02h last=%0b, got %0b %02h %0b",
                     next_expected.is_data, next_expected.lcd_byte, next_expected.last,
                     out_is_data, out_lcd_byte, out_last);
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Home, each row base and the column extremes.
  task automatic test_cursor_addressing();
    send_request(3'd0, 6'd0, 16'd7, 4'd1);
    send_request(3'd0, 6'd17, 16'd7, 4'd1);
    send_request(3'd3, 6'd0, 16'd7, 4'd1);
    send_request(3'd1, 6'd1, 16'd42, 4'd2);
    send_request(3'd1, 6'd63, 16'd42, 4'd2);
    send_request(3'd2, 6'd1, 16'd9, 4'd1);
    send_request(3'd2, 6'd63, 16'd9, 4'd1);
    send_request(3'd3, 6'd20, 16'd123, 4'd3);
    send_request(3'd4, 6'd1, 16'd5, 4'd1);
    send_request(3'd4, 6'd32, 16'd5, 4'd1);
  endtask

  // Every digit count, the value extremes and the error character.
  task automatic test_digit_counts();
    for (int c = 0; c <= lcd_dfw_pkg::MAX_DIGITS; c++)
      send_request(3'd1, 6'd5, 16'hFFFF, 4'(c));
    send_request(3'd2, 6'd3, 16'd0, 4'd5);
    send_request(3'd2, 6'd3, 16'd9999, 4'd4);
    send_request(3'd3, 6'd3, 16'd12345, 4'd6);
    send_request(3'd4, 6'd3, 16'd12345, 4'd15);
  endtask

  // Empty requests, lone error byte, lone command and address wrap-around.
  task automatic test_special_cases();
    send_request(3'd5, 6'd1, 16'd321, 4'd0);
    send_request(3'd7, 6'd63, 16'hFFFF, 4'd0);
    send_request(3'd6, 6'd40, 16'd77, 4'd15);
    send_request(3'd0, 6'd0, 16'd0, 4'd0);
    send_request(3'd4, 6'd63, 16'd60000, 4'd5);
  endtask

  // Random requests, with idling switched on and off in stretches when allowed.
  task automatic test_random_requests(input int num_requests, input bit allow_idle);
    logic [5:0]  column;
    logic [15:0] value;
    logic [3:0]  count;
    for (int i = 0; i < num_requests; i++) begin
      if (i % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      column = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
        0:       value = 16'($urandom_range(0, 9));
        1:       value = 16'($urandom_range(0, 9999));
        default: value = 16'($urandom_range(0, 65535));
      endcase
      count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15))
                                          : 4'($urandom_range(0, lcd_dfw_pkg::MAX_DIGITS));
      send_request(3'($urandom_range(0, 7)), column, value, count);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cursor_addressing();
    test_digit_counts();
    test_special_cases();
    test_random_requests(400, 1'b1);
    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_requests(80, 1'b0);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
